// ===== sv/qrp_pkg.sv =====
// Package with the types, constants and term table of the quaternion rate propagator.
`default_nettype none

package qrp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int STEP_W         = 31;
    localparam int OPND_W         = 33;
    localparam int PROD_W         = 2 * OPND_W;
    localparam int ACC_W          = 70;

    localparam int D_LSB          = 28;
    localparam int D_MSB          = 64;
    localparam int SPLIT          = 16;
    localparam int INC_LSB        = 31;
    localparam int INC_W          = ACC_W - INC_LSB;
    localparam int SUM_W          = INC_W + 1;

    localparam logic signed [FIELD_W-1:0] Q_ONE      = 32'sh2000_0000;
    localparam logic [STEP_W-1:0]         STEP_RESET = 31'd21474836;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rate_x;
        logic signed [FIELD_W-1:0] rate_y;
        logic signed [FIELD_W-1:0] rate_z;
        logic                      reload_flag;
        logic signed [FIELD_W-1:0] ref_q0;
        logic signed [FIELD_W-1:0] ref_q1;
        logic signed [FIELD_W-1:0] ref_q2;
        logic signed [FIELD_W-1:0] ref_q3;
    } qrp_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] att_q0;
        logic signed [FIELD_W-1:0] att_q1;
        logic signed [FIELD_W-1:0] att_q2;
        logic signed [FIELD_W-1:0] att_q3;
    } qrp_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } qrp_state_t;

    typedef enum logic [2:0] {
        PH_TERM0,
        PH_TERM1,
        PH_TERM2,
        PH_DRAIN,
        PH_HIGH,
        PH_LOW,
        PH_MERGE,
        PH_WRITE
    } phase_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB,
        ACC_LOAD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        OPND_TERM,
        OPND_HIGH,
        OPND_LOW
    } opnd_sel_t;

    typedef enum logic [1:0] {
        RATE_X,
        RATE_Y,
        RATE_Z
    } rate_sel_t;

    typedef struct packed {
        rate_sel_t  rate;
        logic [1:0] q_idx;
        logic       neg;
    } term_t;

    typedef struct packed {
        logic       mul_en;
        opnd_sel_t  opnd;
        rate_sel_t  rate;
        logic [1:0] q_idx;
        acc_op_t    acc_op;
        logic       wr_en;
        logic       commit;
        logic [1:0] comp;
    } qrp_ctrl_t;

    // One row of the skew rate matrix times the quaternion, as three signed terms.
    function automatic term_t term_info(input logic [1:0] comp, input logic [1:0] idx);
        term_t t;
        t = '{rate: RATE_X, q_idx: 2'd0, neg: 1'b0};
        case ({comp, idx})
            4'b00_00: t = '{rate: RATE_Z, q_idx: 2'd1, neg: 1'b0};
            4'b00_01: t = '{rate: RATE_Y, q_idx: 2'd2, neg: 1'b1};
            4'b00_10: t = '{rate: RATE_X, q_idx: 2'd3, neg: 1'b0};
            4'b01_00: t = '{rate: RATE_Z, q_idx: 2'd0, neg: 1'b1};
            4'b01_01: t = '{rate: RATE_X, q_idx: 2'd2, neg: 1'b0};
            4'b01_10: t = '{rate: RATE_Y, q_idx: 2'd3, neg: 1'b0};
            4'b10_00: t = '{rate: RATE_Y, q_idx: 2'd0, neg: 1'b0};
            4'b10_01: t = '{rate: RATE_X, q_idx: 2'd1, neg: 1'b1};
            4'b10_10: t = '{rate: RATE_Z, q_idx: 2'd3, neg: 1'b0};
            4'b11_00: t = '{rate: RATE_X, q_idx: 2'd0, neg: 1'b1};
            4'b11_01: t = '{rate: RATE_Y, q_idx: 2'd1, neg: 1'b1};
            4'b11_10: t = '{rate: RATE_Z, q_idx: 2'd2, neg: 1'b1};
            default:  t = '{rate: RATE_X, q_idx: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qrp_mac.sv =====
// Shared multiplier with product register and wide accumulator.
`default_nettype none

module qrp_mac
    import qrp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire qrp_ctrl_t                ctrl,
    input  wire logic signed [OPND_W-1:0] op_a,
    input  wire logic signed [OPND_W-1:0] op_b,
    output logic signed [ACC_W-1:0]       acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        case (ctrl.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_CLEAR:   acc_next = '0;
            ACC_ADD:     acc_next = acc_reg + prod_ext;
            ACC_SUB:     acc_next = acc_reg - prod_ext;
            ACC_LOAD_HI: acc_next = {prod_ext[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== sv/qrp_seq.sv =====
// Sequencer that steps the shared multiplier through the four quaternion components.
`default_nettype none

module qrp_seq
    import qrp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output qrp_ctrl_t ctrl
);

    qrp_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] comp_reg, comp_next;
    logic       last;
    term_t      mul_term;
    term_t      acc_term;

    assign last = (comp_reg == 2'd3) && (phase_reg == PH_WRITE);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        comp_next  = comp_reg;
        case (state_reg)
            ST_IDLE: begin
                phase_next = PH_TERM0;
                comp_next  = 2'd0;
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                phase_next = phase_t'(phase_reg + 3'd1);
                if (phase_reg == PH_WRITE) begin
                    comp_next = comp_reg + 2'd1;
                end
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_TERM0;
            comp_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
        end
    end

    assign mul_term = term_info(comp_reg, phase_reg[1:0]);
    assign acc_term = term_info(comp_reg, phase_reg[1:0] - 2'd1);

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        m_valid     = (state_reg == ST_DONE);
        ctrl.mul_en = 1'b0;
        ctrl.opnd   = OPND_TERM;
        ctrl.rate   = mul_term.rate;
        ctrl.q_idx  = mul_term.q_idx;
        ctrl.acc_op = ACC_HOLD;
        ctrl.wr_en  = 1'b0;
        ctrl.commit = 1'b0;
        ctrl.comp   = comp_reg;
        if (state_reg == ST_RUN) begin
            case (phase_reg)
                PH_TERM0: begin
                    ctrl.mul_en = 1'b1;
                    ctrl.acc_op = ACC_CLEAR;
                end
                PH_TERM1, PH_TERM2: begin
                    ctrl.mul_en = 1'b1;
                    ctrl.acc_op = acc_term.neg ? ACC_SUB : ACC_ADD;
                end
                PH_DRAIN: begin
                    ctrl.acc_op = acc_term.neg ? ACC_SUB : ACC_ADD;
                end
                PH_HIGH: begin
                    ctrl.mul_en = 1'b1;
                    ctrl.opnd   = OPND_HIGH;
                end
                PH_LOW: begin
                    ctrl.mul_en = 1'b1;
                    ctrl.opnd   = OPND_LOW;
                    ctrl.acc_op = ACC_LOAD_HI;
                end
                PH_MERGE: begin
                    ctrl.acc_op = ACC_ADD;
                end
                PH_WRITE: begin
                    ctrl.wr_en  = 1'b1;
                    ctrl.commit = last;
                end
                default: ctrl.acc_op = ACC_HOLD;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/quaternion_rate_propagator.sv =====
// Top level of the quaternion rate propagator: state, operand selection and saturation.
// Handshake: m_valid rises once all four components have been computed, and a new
// request is accepted only after the previous result has been taken.
// The four components are computed one after another on the single shared
// 33 x 33 multiplier and its accumulator.
// Reset: aresetn is synchronous and active low; it sets every attitude component to
// 1.0, clears the previous reload flag and loads the default step time.
`default_nettype none

module quaternion_rate_propagator
    import qrp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qrp_req_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qrp_rsp_t               m_data,
    input  wire logic              cfg_we,
    input  wire logic [STEP_W-1:0] cfg_wdata
);

    localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    qrp_ctrl_t                  ctrl;
    qrp_req_t                   in_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       prev_reload_reg;
    logic signed [FIELD_W-1:0]  att_reg [4];
    logic signed [FIELD_W-1:0]  new_q_reg [3];
    logic signed [ACC_W-1:0]    acc;
    logic signed [OPND_W-1:0]   op_a;
    logic signed [OPND_W-1:0]   op_b;
    logic signed [FIELD_W-1:0]  rate_val;
    logic signed [FIELD_W-1:0]  ref_val;
    logic signed [FIELD_W-1:0]  base_val;
    logic signed [SUM_W-1:0]    sum_val;
    logic signed [FIELD_W-1:0]  sat_val;
    logic                       reload_now;
    logic                       s_fire;

    assign s_fire = s_valid && s_ready;

    qrp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    always_comb begin
        case (ctrl.rate)
            RATE_X:  rate_val = in_reg.rate_x;
            RATE_Y:  rate_val = in_reg.rate_y;
            RATE_Z:  rate_val = in_reg.rate_z;
            default: rate_val = in_reg.rate_x;
        endcase
    end

    always_comb begin
        case (ctrl.opnd)
            OPND_TERM: begin
                op_a = OPND_W'(rate_val);
                op_b = OPND_W'(att_reg[ctrl.q_idx]);
            end
            OPND_HIGH: begin
                op_a = OPND_W'($signed(acc[D_MSB:D_LSB+SPLIT]));
                op_b = {{(OPND_W-STEP_W){1'b0}}, step_reg};
            end
            OPND_LOW: begin
                op_a = {{(OPND_W-SPLIT){1'b0}}, acc[D_LSB+SPLIT-1:D_LSB]};
                op_b = {{(OPND_W-STEP_W){1'b0}}, step_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    qrp_mac u_mac (
        .aclk (aclk),
        .ctrl (ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    always_comb begin
        case (ctrl.comp)
            2'd0:    ref_val = in_reg.ref_q0;
            2'd1:    ref_val = in_reg.ref_q1;
            2'd2:    ref_val = in_reg.ref_q2;
            2'd3:    ref_val = in_reg.ref_q3;
            default: ref_val = in_reg.ref_q0;
        endcase
    end

    // The reference replaces only the base; the derivative still uses the stored attitude.
    assign reload_now = prev_reload_reg && !in_reg.reload_flag;
    assign base_val   = reload_now ? ref_val : att_reg[ctrl.comp];
    assign sum_val    = SUM_W'(base_val) + SUM_W'($signed(acc[ACC_W-1:INC_LSB]));

    always_comb begin
        if (sum_val > SAT_HI) begin
            sat_val = FIELD_W'(SAT_HI);
        end else if (sum_val < SAT_LO) begin
            sat_val = FIELD_W'(SAT_LO);
        end else begin
            sat_val = FIELD_W'(sum_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
        if (ctrl.wr_en && !ctrl.commit) begin
            new_q_reg[ctrl.comp] <= sat_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= STEP_RESET;
            prev_reload_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                att_reg[i] <= Q_ONE;
            end
        end else begin
            if (cfg_we) begin
                step_reg <= cfg_wdata;
            end
            if (ctrl.commit) begin
                att_reg[0]      <= new_q_reg[0];
                att_reg[1]      <= new_q_reg[1];
                att_reg[2]      <= new_q_reg[2];
                att_reg[3]      <= sat_val;
                prev_reload_reg <= in_reg.reload_flag;
            end
        end
    end

    assign m_data = '{att_q0: att_reg[0], att_q1: att_reg[1],
                      att_q2: att_reg[2], att_q3: att_reg[3]};

endmodule

`default_nettype wire

// ===== test/quaternion_rate_propagator_tb.sv =====
// Self-checking testbench of the quaternion rate propagator with a cycle-free predictor.
`timescale 1ns / 1ps

module quaternion_rate_propagator_tb;
    import qrp_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        logic              new_step;
        logic [STEP_W-1:0] step;
        qrp_req_t          req;
        logic              typed;
        qrp_rsp_t          rsp;
    } dir_row_t;

    localparam int LIMIT = 400000;
    localparam int NDIR  = 21;
    localparam int NPH   = 6;
    localparam int PH_LEN = 130;

    localparam logic signed [31:0] HI = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LO = 32'sh8000_0000;
    localparam logic signed [31:0] Z  = 32'sh0000_0000;
    localparam logic signed [31:0] M1 = 32'shFFFF_FFFF;
    localparam logic signed [31:0] P1 = 32'sh0000_0001;
    localparam logic signed [31:0] Q1 = Q_ONE;
    localparam logic signed [31:0] QH = 32'sh1000_0000;
    localparam logic signed [31:0] NQ = 32'shE000_0000;
    localparam logic [STEP_W-1:0] NO_STEP  = '0;
    localparam logic [STEP_W-1:0] STEP_MAX = 31'h7FFF_FFFF;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    qrp_req_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    qrp_rsp_t          m_data;
    logic              cfg_we = 1'b0;
    logic [STEP_W-1:0] cfg_wdata = '0;

    logic signed [31:0] att_q [4] = '{Q1, Q1, Q1, Q1};
    logic               prev_reload_m = 1'b0;
    logic [STEP_W-1:0]  step_m = STEP_RESET;

    qrp_rsp_t pending_att [$];
    logic     typed_on = 1'b0;
    qrp_rsp_t typed_rsp = '0;
    logic     idle_on = 1'b1;
    logic     stall_on = 1'b1;
    logic     rl_walk = 1'b0;
    int       errors = 0;
    int       cycles = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_reload = 0;
    int       n_steps = 0;

    dir_row_t dir_tab [NDIR] = '{
        {1'b0, NO_STEP, Z, Z, Z, 1'b0, HI, LO, HI, LO, 1'b1, Q1, Q1, Q1, Q1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b1, HI, LO, HI, LO, 1'b1, Q1, Q1, Q1, Q1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b1, LO, HI, Z, M1, 1'b1, Q1, Q1, Q1, Q1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b0, HI, LO, Z, M1, 1'b1, HI, LO, Z, M1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b0, Q1, Q1, Q1, Q1, 1'b1, HI, LO, Z, M1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b1, Z, Z, Z, Z, 1'b1, HI, LO, Z, M1},
        {1'b0, NO_STEP, Z, Z, Z, 1'b0, Q1, Z, Z, Z, 1'b1, Q1, Z, Z, Z},
        {1'b0, NO_STEP, HI, HI, HI, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, LO, LO, LO, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, HI, LO, Z, 1'b1, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, LO, HI, M1, 1'b0, QH, QH, QH, QH, 1'b0, {4{Z}}},
        {1'b1, STEP_MAX, HI, HI, HI, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, LO, LO, LO, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, M1, M1, M1, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, P1, P1, P1, 1'b1, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, HI, HI, HI, 1'b0, LO, LO, LO, LO, 1'b0, {4{Z}}},
        {1'b1, NO_STEP, HI, LO, HI, 1'b1, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, LO, HI, LO, 1'b0, HI, NQ, QH, LO, 1'b1, HI, NQ, QH, LO},
        {1'b0, NO_STEP, HI, HI, HI, 1'b0, Z, Z, Z, Z, 1'b1, HI, NQ, QH, LO},
        {1'b1, 31'd1, HI, HI, HI, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}},
        {1'b0, NO_STEP, LO, LO, LO, 1'b0, Z, Z, Z, Z, 1'b0, {4{Z}}}
    };

    quaternion_rate_propagator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic qrp_rsp_t propagate(input qrp_req_t r);
        wide_t x, y, z, stp, nxt;
        wide_t q [4];
        wide_t rq [4];
        wide_t d [4];
        logic signed [31:0] res [4];
        logic edge_seen;
        int i;
        x = $signed(r.rate_x);
        y = $signed(r.rate_y);
        z = $signed(r.rate_z);
        for (i = 0; i < 4; i++) begin
            q[i] = att_q[i];
        end
        rq[0] = $signed(r.ref_q0);
        rq[1] = $signed(r.ref_q1);
        rq[2] = $signed(r.ref_q2);
        rq[3] = $signed(r.ref_q3);
        stp = {65'd0, step_m};
        d[0] = (z * q[1] - y * q[2] + x * q[3]) >>> 28;
        d[1] = (x * q[2] + y * q[3] - z * q[0]) >>> 28;
        d[2] = (y * q[0] - x * q[1] + z * q[3]) >>> 28;
        d[3] = (-(x * q[0]) - y * q[1] - z * q[2]) >>> 28;
        edge_seen = prev_reload_m && !r.reload_flag;
        if (edge_seen) begin
            n_reload++;
        end
        for (i = 0; i < 4; i++) begin
            nxt = (edge_seen ? rq[i] : q[i]) + ((d[i] * stp) >>> 31);
            if (nxt > HI) begin
                res[i] = HI;
            end else if (nxt < LO) begin
                res[i] = LO;
            end else begin
                res[i] = nxt[31:0];
            end
            att_q[i] = res[i];
        end
        prev_reload_m = r.reload_flag;
        return {res[0], res[1], res[2], res[3]};
    endfunction

    function automatic logic signed [31:0] pick_rate();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = HI;
            1: v = LO;
            2: v = Z;
            3, 4: v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h2000_0000);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pick_ref();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? HI : LO;
            2: v = Z;
            default: begin
                v = $urandom_range(0, Q1);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input qrp_req_t r, input logic has_typed, input qrp_rsp_t t);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_data <= r;
        s_valid <= 1'b1;
        typed_on = has_typed;
        typed_rsp = t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_step(input logic [STEP_W-1:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_att.size() != 0) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        step_m = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_steps++;
    endtask

    always @(posedge aclk) begin
        qrp_rsp_t want;
        int i;
        cycles++;
        if (cycles >= LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_att.size());
            $display("end of test: mismatches");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_att.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                want = pending_att.pop_front();
                n_checked++;
                for (i = 0; i < 4; i++) begin
                    if (m_data[127 - 32 * i -: 32] !== want[127 - 32 * i -: 32]) begin
                        $display("%0t: att_q%0d expected %h actual %h", $time, i,
                                 want[127 - 32 * i -: 32], m_data[127 - 32 * i -: 32]);
                        errors++;
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            want = propagate(s_data);
            pending_att.push_back(typed_on ? typed_rsp : want);
            n_sent++;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge aclk);
        end
    end

    initial begin
        qrp_req_t r;
        logic [STEP_W-1:0] nstep;
        int k;
        int ph;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < NDIR; k++) begin
            if (dir_tab[k].new_step) begin
                set_step(dir_tab[k].step);
            end
            send_item(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);
        end

        for (ph = 0; ph < NPH; ph++) begin
            case (ph)
                0: nstep = 31'd1;
                1: nstep = $urandom;
                2: nstep = STEP_MAX;
                3: nstep = '0;
                4: nstep = $urandom_range(1, 32'h0200_0000);
                default: begin
                    nstep = STEP_RESET;
                    idle_on = 1'b0;
                    stall_on = 1'b0;
                end
            endcase
            set_step(nstep);
            repeat (PH_LEN) begin
                if ($urandom_range(0, 3) == 0) begin
                    rl_walk = ~rl_walk;
                end
                r.rate_x = pick_rate();
                r.rate_y = pick_rate();
                r.rate_z = pick_rate();
                r.reload_flag = rl_walk;
                r.ref_q0 = pick_ref();
                r.ref_q1 = pick_ref();
                r.ref_q2 = pick_ref();
                r.ref_q3 = pick_ref();
                send_item(r, 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_att.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("Sent %0d requests, %0d of them reloading the attitude, under %0d step values.",
                 n_sent, n_reload, n_steps);
        $display("Checked %0d results; %0d field mismatches.", n_checked, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
